/* rtl/mbwa_pkg.sv */
package mbwa_pkg;

  localparam int MAX_BOXES_DEFAULT   = 256;
  localparam int COORD_WIDTH_DEFAULT = 10;

  localparam int SLOT_W      = 8;
  localparam int WEIGHT_W    = 16;
  localparam int LABEL_W     = 16;
  localparam int HEAT_W      = 24;
  localparam int MASK_W      = 16;
  localparam int COUNT_W     = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int AXES        = 3;

  localparam int HEAT_MAX = 8388607;
  localparam int HEAT_MIN = -8388608;

  localparam logic [CFG_INDEX_W-1:0] REG_MASK_VALUE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_COUNT  = 1'b1;

  localparam logic [MASK_W-1:0]  MASK_VALUE_RESET = 16'd1;
  localparam logic [COUNT_W-1:0] BOX_COUNT_RESET  = 9'd0;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_VOXEL = 1'b1
  } op_t;

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic              sel;
    logic [SLOT_W-1:0] slot;
  } ctrl_t;

endpackage

/* rtl/mbwa_item_if.sv */
interface mbwa_item_if #(
  parameter int CoordWidth = mbwa_pkg::COORD_WIDTH_DEFAULT
);
  import mbwa_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [SLOT_W-1:0]          slot;
  logic [CoordWidth-1:0]      pos_x;
  logic [CoordWidth-1:0]      pos_y;
  logic [CoordWidth-1:0]      pos_z;
  logic [CoordWidth:0]        size_x;
  logic [CoordWidth:0]        size_y;
  logic [CoordWidth:0]        size_z;
  logic signed [WEIGHT_W-1:0] weight;
  logic [LABEL_W-1:0]         label;

  modport source (
    output valid, operation, slot, pos_x, pos_y, pos_z, size_x, size_y, size_z, weight, label,
    input  ready
  );

  modport sink (
    input  valid, operation, slot, pos_x, pos_y, pos_z, size_x, size_y, size_z, weight, label,
    output ready
  );

endinterface

/* rtl/mbwa_result_if.sv */
interface mbwa_result_if;
  import mbwa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [HEAT_W-1:0] heat;
  logic                     in_mask;

  modport source (
    output valid, heat, in_mask,
    input  ready
  );

  modport sink (
    input  valid, heat, in_mask,
    output ready
  );

endinterface

/* rtl/mbwa_cell.sv */
module mbwa_cell #(
  parameter int Index      = 0,
  parameter int CoordWidth = mbwa_pkg::COORD_WIDTH_DEFAULT,
  parameter int SumWidth   = mbwa_pkg::HEAT_W + 1
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       advance,
  input  logic [mbwa_pkg::COUNT_W-1:0]               box_count,
  input  mbwa_pkg::ctrl_t                            ctrl_in,
  input  logic [mbwa_pkg::AXES*CoordWidth-1:0]       pos_in,
  input  logic [mbwa_pkg::AXES*(CoordWidth+1)-1:0]   size_in,
  input  logic signed [mbwa_pkg::WEIGHT_W-1:0]       weight_in,
  input  logic signed [SumWidth-1:0]                 sum_in,
  output mbwa_pkg::ctrl_t                            ctrl_out,
  output logic [mbwa_pkg::AXES*CoordWidth-1:0]       pos_out,
  output logic [mbwa_pkg::AXES*(CoordWidth+1)-1:0]   size_out,
  output logic signed [mbwa_pkg::WEIGHT_W-1:0]       weight_out,
  output logic signed [SumWidth-1:0]                 sum_out
);
  import mbwa_pkg::*;

  localparam int BoundW = CoordWidth + 2;

  logic [BoundW-1:0]          box_lo [AXES];
  logic [BoundW-1:0]          box_hi [AXES];
  logic signed [WEIGHT_W-1:0] box_wgt;

  logic [AXES-1:0] axis_hit;
  logic            active;
  logic            hit;
  logic            load_here;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      axis_hit[a] = (BoundW'(pos_in[a*CoordWidth +: CoordWidth]) >= box_lo[a]) &&
                    (BoundW'(pos_in[a*CoordWidth +: CoordWidth]) < box_hi[a]);
    end
    active    = int'(box_count) > Index;
    hit       = ctrl_in.valid && (ctrl_in.op == OP_VOXEL) && ctrl_in.sel && active &&
                (&axis_hit);
    load_here = ctrl_in.valid && (ctrl_in.op == OP_LOAD) && (int'(ctrl_in.slot) == Index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (advance) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctrl_out.op   <= ctrl_in.op;
      ctrl_out.sel  <= ctrl_in.sel;
      ctrl_out.slot <= ctrl_in.slot;
      pos_out       <= pos_in;
      size_out      <= size_in;
      weight_out    <= weight_in;
      sum_out       <= hit ? sum_in + SumWidth'(box_wgt) : sum_in;
      if (load_here) begin
        for (int a = 0; a < AXES; a++) begin
          box_lo[a] <= BoundW'(pos_in[a*CoordWidth +: CoordWidth]);
          box_hi[a] <= BoundW'(pos_in[a*CoordWidth +: CoordWidth]) +
                       BoundW'(size_in[a*(CoordWidth+1) +: CoordWidth+1]);
        end
        box_wgt <= weight_in;
      end
    end
  end

endmodule

/* rtl/masked_box_weight_accumulator.sv */
// Channel   Modport   Payload                                              Handshake
// items     sink      operation slot pos_x/y/z size_x/y/z weight label     valid/ready
// results   source    heat in_mask                                         valid/ready
// cfg       write     cfg_we cfg_index cfg_data                            none
//
// Every item walks a chain of MAX_BOXES cells, one box per cell, then an output register;
// one item is accepted per cycle while results flow.
// Load items write their box when they reach the cell of their slot and give no result.
// A waiting result holds the whole chain; items.ready is low for exactly those cycles.
// Reset clears valid bits and the config registers; box contents stay undefined until loaded.
module masked_box_weight_accumulator #(
  parameter int MAX_BOXES   = mbwa_pkg::MAX_BOXES_DEFAULT,
  parameter int COORD_WIDTH = mbwa_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mbwa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbwa_pkg::CFG_DATA_W-1:0]  cfg_data,
  mbwa_item_if.sink                        items,
  mbwa_result_if.source                    results
);
  import mbwa_pkg::*;

  localparam int SumRaw   = WEIGHT_W + $clog2(MAX_BOXES + 1);
  localparam int SumWidth = (SumRaw > HEAT_W) ? SumRaw : HEAT_W + 1;
  localparam int PosW     = AXES * COORD_WIDTH;
  localparam int SizeW    = AXES * (COORD_WIDTH + 1);

  localparam logic signed [SumWidth-1:0] SumHi = SumWidth'(HEAT_MAX);
  localparam logic signed [SumWidth-1:0] SumLo = SumWidth'(HEAT_MIN);

  logic [MASK_W-1:0]  mask_value;
  logic [COUNT_W-1:0] box_count;
  logic               advance;

  ctrl_t                      chain_ctrl   [MAX_BOXES+1];
  logic [PosW-1:0]            chain_pos    [MAX_BOXES+1];
  logic [SizeW-1:0]           chain_size   [MAX_BOXES+1];
  logic signed [WEIGHT_W-1:0] chain_weight [MAX_BOXES+1];
  logic signed [SumWidth-1:0] chain_sum    [MAX_BOXES+1];

  logic                     out_valid;
  logic                     out_valid_next;
  logic signed [HEAT_W-1:0] heat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_value <= MASK_VALUE_RESET;
      box_count  <= BOX_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASK_VALUE: mask_value <= cfg_data[MASK_W-1:0];
        REG_BOX_COUNT:  box_count  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = !out_valid || results.ready;
  assign items.ready = advance;

  always_comb begin
    chain_ctrl[0].valid = items.valid;
    chain_ctrl[0].op    = op_t'(items.operation);
    chain_ctrl[0].sel   = (items.label == mask_value);
    chain_ctrl[0].slot  = items.slot;
    chain_pos[0]        = {items.pos_z, items.pos_y, items.pos_x};
    chain_size[0]       = {items.size_z, items.size_y, items.size_x};
    chain_weight[0]     = items.weight;
    chain_sum[0]        = '0;
  end

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    mbwa_cell #(
      .Index      (i),
      .CoordWidth (COORD_WIDTH),
      .SumWidth   (SumWidth)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .box_count  (box_count),
      .ctrl_in    (chain_ctrl[i]),
      .pos_in     (chain_pos[i]),
      .size_in    (chain_size[i]),
      .weight_in  (chain_weight[i]),
      .sum_in     (chain_sum[i]),
      .ctrl_out   (chain_ctrl[i+1]),
      .pos_out    (chain_pos[i+1]),
      .size_out   (chain_size[i+1]),
      .weight_out (chain_weight[i+1]),
      .sum_out    (chain_sum[i+1])
    );
  end

  always_comb begin
    out_valid_next = chain_ctrl[MAX_BOXES].valid && (chain_ctrl[MAX_BOXES].op == OP_VOXEL);
    priority if (chain_sum[MAX_BOXES] > SumHi) begin
      heat_next = SumHi[HEAT_W-1:0];
    end else if (chain_sum[MAX_BOXES] < SumLo) begin
      heat_next = SumLo[HEAT_W-1:0];
    end else begin
      heat_next = chain_sum[MAX_BOXES][HEAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.heat    <= heat_next;
      results.in_mask <= chain_ctrl[MAX_BOXES].sel;
    end
  end

  assign results.valid = out_valid;

endmodule

/* rtl/mbwa_checker.sv */
module mbwa_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [mbwa_pkg::HEAT_W-1:0]    out_heat,
  input logic                                  out_in_mask
);
  import mbwa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_heat) && $stable(out_in_mask))
    else $error("result changed while stalled");

  a_unmasked_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_in_mask |-> out_heat == '0)
    else $error("unselected voxel with nonzero heat");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind masked_box_weight_accumulator mbwa_checker u_mbwa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (items.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_heat    (results.heat),
  .out_in_mask (results.in_mask)
);

/* bench/heat_checker.sv */
module heat_checker
  import mbwa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mbwa_item_if                   items,
  mbwa_result_if                 results,
  output int                     fails,
  output int                     pending
);

  localparam int NB           = MAX_BOXES_DEFAULT;
  localparam int CW           = COORD_WIDTH_DEFAULT;
  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    logic signed [HEAT_W-1:0] heat;
    logic                     in_mask;
  } heat_t;

  logic [CW-1:0]              box_lo  [NB][AXES];
  logic [CW:0]                box_len [NB][AXES];
  logic signed [WEIGHT_W-1:0] box_w   [NB];
  logic [MASK_W-1:0]          mask_value;
  logic [COUNT_W-1:0]         box_count;
  heat_t                      heat_due [$];
  int                         errors = 0;

  function automatic logic signed [HEAT_W-1:0] voxel_heat(input logic [CW-1:0] px, py, pz);
    int pos [AXES];
    int lim, total, e, a;
    bit hit;
    pos[0] = int'(px);
    pos[1] = int'(py);
    pos[2] = int'(pz);
    lim = (int'(box_count) > NB) ? NB : int'(box_count);
    total = 0;
    for (e = 0; e < lim; e++) begin
      hit = 1'b1;
      for (a = 0; a < AXES; a++) begin
        if (pos[a] < int'(box_lo[e][a]) ||
            pos[a] >= int'(box_lo[e][a]) + int'(box_len[e][a])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        total += box_w[e];
      end
    end
    if (total > HEAT_MAX) total = HEAT_MAX;
    if (total < HEAT_MIN) total = HEAT_MIN;
    return total[HEAT_W-1:0];
  endfunction

  always @(posedge clk) begin
    heat_t got, want;
    if (rst) begin
      mask_value = MASK_VALUE_RESET;
      box_count  = BOX_COUNT_RESET;
      heat_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MASK_VALUE) begin
          mask_value = cfg_data[MASK_W-1:0];
        end else if (cfg_index == REG_BOX_COUNT) begin
          box_count = cfg_data[COUNT_W-1:0];
        end
      end
      if (results.valid && results.ready) begin
        got.heat    = results.heat;
        got.in_mask = results.in_mask;
        if (heat_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: expected no result, got heat %0d in_mask %0b",
                     $time, got.heat, got.in_mask);
          end
        end else begin
          want = heat_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("%0t: expected heat %0d in_mask %0b, got heat %0d in_mask %0b",
                       $time, want.heat, want.in_mask, got.heat, got.in_mask);
            end
          end
        end
      end
      if (items.valid && items.ready) begin
        if (op_t'(items.operation) == OP_LOAD) begin
          if (int'(items.slot) < NB) begin
            box_lo[items.slot][0]  = items.pos_x;
            box_lo[items.slot][1]  = items.pos_y;
            box_lo[items.slot][2]  = items.pos_z;
            box_len[items.slot][0] = items.size_x;
            box_len[items.slot][1] = items.size_y;
            box_len[items.slot][2] = items.size_z;
            box_w[items.slot]      = items.weight;
          end
        end else if (items.label != mask_value) begin
          want.heat    = '0;
          want.in_mask = 1'b0;
          heat_due.push_back(want);
        end else begin
          want.heat    = voxel_heat(items.pos_x, items.pos_y, items.pos_z);
          want.in_mask = 1'b1;
          heat_due.push_back(want);
        end
      end
    end
    fails   <= errors;
    pending <= heat_due.size();
  end

endmodule

/* bench/tb_top.sv */
module tb_top;
  import mbwa_pkg::*;

  localparam int NB             = MAX_BOXES_DEFAULT;
  localparam int CW             = COORD_WIDTH_DEFAULT;
  localparam int COORD_MAX      = (1 << CW) - 1;
  localparam int FULL_LEN       = 1 << CW;
  localparam int DRAIN_CYCLES   = NB + 24;
  localparam int WATCHDOG_LIMIT = 20 * NB;
  localparam int ROUNDS         = 9;
  localparam int ROUND_ITEMS    = 80;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     src_idle_pct;
  int                     rcv_idle_pct;
  int                     fails;
  int                     pending;
  int                     quiet_cycles = 0;
  int                     tgt_lo  [NB][AXES];
  int                     tgt_len [NB][AXES];
  logic [MASK_W-1:0]      cur_mask;
  int                     cur_count;

  mbwa_item_if   items_if ();
  mbwa_result_if results_if ();

  masked_box_weight_accumulator u_top (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .items   (items_if),
    .results (results_if)
  );

  heat_checker u_chk (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .items   (items_if),
    .results (results_if),
    .fails,
    .pending
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    results_if.ready <= !rst && ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) ||
        (results_if.valid && results_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_item(input op_t op, input int slot, input int px, input int py,
                          input int pz, input int sx, input int sy, input int sz,
                          input int w, input int label);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      items_if.valid     <= 1'b0;
      items_if.operation <= 1'($urandom);
      items_if.pos_x     <= CW'($urandom);
      items_if.label     <= LABEL_W'($urandom);
      @(negedge clk);
    end
    items_if.valid     <= 1'b1;
    items_if.operation <= op;
    items_if.slot      <= slot[SLOT_W-1:0];
    items_if.pos_x     <= px[CW-1:0];
    items_if.pos_y     <= py[CW-1:0];
    items_if.pos_z     <= pz[CW-1:0];
    items_if.size_x    <= sx[CW:0];
    items_if.size_y    <= sy[CW:0];
    items_if.size_z    <= sz[CW:0];
    items_if.weight    <= w[WEIGHT_W-1:0];
    items_if.label     <= label[LABEL_W-1:0];
    do @(posedge clk); while (items_if.ready !== 1'b1);
  endtask

  task automatic load_box(input int slot, input int x0, input int y0, input int z0,
                          input int dx, input int dy, input int dz, input int w);
    tgt_lo[slot][0]  = x0;
    tgt_lo[slot][1]  = y0;
    tgt_lo[slot][2]  = z0;
    tgt_len[slot][0] = dx;
    tgt_len[slot][1] = dy;
    tgt_len[slot][2] = dz;
    put_item(OP_LOAD, slot, x0, y0, z0, dx, dy, dz, w, $urandom);
  endtask

  task automatic score(input int px, input int py, input int pz, input int label);
    put_item(OP_VOXEL, $urandom, px, py, pz, $urandom, $urandom, $urandom, $urandom, label);
  endtask

  task automatic load_random(input int slot);
    int lo [AXES];
    int len [AXES];
    int a, pick, w;
    for (a = 0; a < AXES; a++) begin
      pick = $urandom_range(99);
      lo[a] = (pick < 5) ? 0 : (pick < 10) ? COORD_MAX : $urandom_range(COORD_MAX);
      pick = $urandom_range(99);
      len[a] = (pick < 4)  ? 0 :
               (pick < 8)  ? FULL_LEN :
               (pick < 60) ? $urandom_range(64, 1) : $urandom_range(FULL_LEN);
    end
    pick = $urandom_range(99);
    w = (pick < 8) ? -32768 : (pick < 16) ? 32767 : $urandom_range(65535) - 32768;
    load_box(slot, lo[0], lo[1], lo[2], len[0], len[1], len[2], w);
  endtask

  task automatic fill_table(input int w, input bit full_cover);
    int s;
    for (s = 0; s < NB; s++) begin
      if (full_cover) begin
        load_box(s, 0, 0, 0, FULL_LEN, FULL_LEN, FULL_LEN, w);
      end else begin
        load_random(s);
      end
    end
  endtask

  function automatic int near_coord(input int lo, input int len);
    int pick, c;
    pick = $urandom_range(99);
    if (len == 0 || pick < 10) begin
      c = lo + len;
    end else if (pick < 20) begin
      c = lo - 1;
    end else begin
      c = lo + $urandom_range(len - 1);
    end
    if (c < 0 || c > COORD_MAX) begin
      c = $urandom_range(COORD_MAX);
    end
    return c;
  endfunction

  task automatic score_random();
    int label, s, lim;
    label = ($urandom_range(99) < 75) ? int'(cur_mask) : $urandom_range(16'hFFFF);
    lim = (cur_count < 1) ? 1 : (cur_count > NB) ? NB : cur_count;
    if ($urandom_range(99) < 80) begin
      s = $urandom_range(lim - 1);
      score(near_coord(tgt_lo[s][0], tgt_len[s][0]), near_coord(tgt_lo[s][1], tgt_len[s][1]),
            near_coord(tgt_lo[s][2], tgt_len[s][2]), label);
    end else begin
      score($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
            $urandom_range(COORD_MAX), label);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    items_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input int mask, input int count);
    settle();
    write_reg(REG_MASK_VALUE, mask);
    write_reg(REG_BOX_COUNT, count | ($urandom_range(127) << COUNT_W));
    cur_mask  = mask[MASK_W-1:0];
    cur_count = count;
  endtask

  initial begin
    int r, i, mask, count, lim;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_MASK_VALUE;
    cfg_data            = '0;
    items_if.valid      = 1'b0;
    items_if.operation  = OP_LOAD;
    items_if.slot       = '0;
    items_if.pos_x      = '0;
    items_if.pos_y      = '0;
    items_if.pos_z      = '0;
    items_if.size_x     = '0;
    items_if.size_y     = '0;
    items_if.size_z     = '0;
    items_if.weight     = '0;
    items_if.label      = '0;
    results_if.ready    = 1'b0;
    src_idle_pct        = 17;
    rcv_idle_pct        = 73;
    cur_mask            = MASK_VALUE_RESET;
    cur_count           = int'(BOX_COUNT_RESET);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // write every slot before anything can read the table
    fill_table(0, 1'b0);

    score(0, 0, 0, int'(MASK_VALUE_RESET));
    score(COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF);
    score(5, 6, 7, 0);
    load_box(0, 0, 0, 0, FULL_LEN, FULL_LEN, FULL_LEN, -32768);
    load_box(NB - 1, COORD_MAX, COORD_MAX, COORD_MAX, 1, 1, 1, 32767);
    load_box(1, 0, 0, 0, 0, FULL_LEN, FULL_LEN, 32767);
    load_box(2, 100, 200, 300, 1, 1, 1, 1234);
    load_box(3, COORD_MAX, 0, 512, FULL_LEN, FULL_LEN, FULL_LEN, -1);
    configure(16'hFFFF, NB);
    score(0, 0, 0, 16'hFFFF);
    score(COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF);
    score(100, 200, 300, 16'hFFFF);
    score(101, 200, 300, 16'hFFFF);
    score(99, 200, 300, 16'hFFFF);
    score(COORD_MAX, 0, 512, 16'hFFFF);
    score(100, 200, 300, 16'hFFFE);
    configure(0, (1 << COUNT_W) - 1);
    score(0, 0, 0, 0);
    score(COORD_MAX, COORD_MAX, COORD_MAX, 0);
    score(100, 200, 300, 0);
    score(0, 0, 0, 1);

    for (r = 0; r < ROUNDS; r++) begin
      case (r / 3)
        0: begin
          src_idle_pct = 17;
          rcv_idle_pct = 73;
        end
        1: begin
          src_idle_pct = 73;
          rcv_idle_pct = 17;
        end
        default: begin
          src_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      if (r == 3) begin
        fill_table(-32768, 1'b1);
      end else if (r == 6) begin
        fill_table(32767, 1'b1);
      end else if (r == 4 || r == 7) begin
        fill_table(0, 1'b0);
      end
      mask = $urandom_range(16'hFFFF);
      case (r)
        0: count = 1;
        1: count = NB / 2;
        2: begin
          mask  = 16'hFFFF;
          count = NB - 1;
        end
        3: begin
          mask  = 0;
          count = NB;
        end
        4: count = 0;
        5: count = (1 << COUNT_W) - 1;
        6: count = NB;
        8: begin
          mask  = 1;
          count = $urandom_range(NB, 1);
        end
        default: count = $urandom_range((1 << COUNT_W) - 1);
      endcase
      configure(mask, count);
      lim = (cur_count < 1) ? 1 : (cur_count > NB) ? NB : cur_count;
      for (i = 0; i < ROUND_ITEMS; i++) begin
        if ($urandom_range(99) < 20) begin
          load_random(($urandom_range(99) < 80) ? $urandom_range(lim - 1) : $urandom_range(NB - 1));
        end else begin
          score_random();
        end
      end
    end

    settle();
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
